// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tier meter. Each one samples on
// i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ALTM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ALTM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/altm_pkg.sv -----
// ----------------------------------------------------------------------------
// Tier meter package
// Widths, register indexes, reset values, FSM states and the gamma table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package altm_pkg;

    localparam int PEAK_W    = 16;
    localparam int LEVEL_W   = 24;
    localparam int TIERS     = 5;
    localparam int SOLID_W   = 3;
    localparam int RAMP_W    = 10;
    localparam int DUTY_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int GAMMA_N   = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_ONE   = 3'd0,
        CFG_THR_TWO   = 3'd1,
        CFG_THR_THREE = 3'd2,
        CFG_THR_FOUR  = 3'd3,
        CFG_THR_FIVE  = 3'd4,
        CFG_WEIGHT    = 3'd5
    } t_cfg_idx;

    localparam logic [PEAK_W-1:0] THR_ONE_RST   = 16'd1311;
    localparam logic [PEAK_W-1:0] THR_TWO_RST   = 16'd9830;
    localparam logic [PEAK_W-1:0] THR_THREE_RST = 16'd22938;
    localparam logic [PEAK_W-1:0] THR_FOUR_RST  = 16'd39322;
    localparam logic [PEAK_W-1:0] THR_FIVE_RST  = 16'd55706;
    localparam logic [PEAK_W-1:0] WEIGHT_RST    = 16'd52429;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMOOTH,
        ST_BAND,
        ST_DIVIDE,
        ST_GAMMA,
        ST_SCALE,
        ST_FINISH
    } t_state;

    // round(65535 * (k/32)^2.2)
    localparam logic [PEAK_W-1:0] GAMMA_ROM [GAMMA_N] = '{
        16'd0,     16'd32,    16'd147,   16'd359,   16'd676,   16'd1104,
        16'd1648,  16'd2314,  16'd3104,  16'd4022,  16'd5072,  16'd6255,
        16'd7574,  16'd9033,  16'd10632, 16'd12375, 16'd14263, 16'd16298,
        16'd18482, 16'd20816, 16'd23303, 16'd25943, 16'd28739, 16'd31692,
        16'd34802, 16'd38072, 16'd41503, 16'd45097, 16'd48853, 16'd52774,
        16'd56860, 16'd61114, 16'd65535
    };

endpackage

// ----- sv/altm_smooth.sv -----
// ----------------------------------------------------------------------------
// Tier meter smoothing unit
// Bit-serial exponential average: level = (w*level + (1-w)*(raw<<8)) >> 16,
// one weight bit per cycle, LSB first, into a right-shifting accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module altm_smooth (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [altm_pkg::PEAK_W-1:0]   i_raw,
    input  logic [altm_pkg::PEAK_W-1:0]   i_weight,
    output logic [altm_pkg::LEVEL_W-1:0]  o_level,
    output logic                          o_done
);
    import altm_pkg::*;

    localparam int CntW  = $clog2(PEAK_W + 1);
    localparam int SumW  = LEVEL_W + 2;
    localparam int PadW  = LEVEL_W - PEAK_W;

    logic                  r_busy;
    logic                  r_done;
    logic [CntW-1:0]       r_cnt;
    logic [PEAK_W-1:0]     r_mul_a;
    logic [PEAK_W:0]       r_mul_b;
    logic [PEAK_W-1:0]     r_raw;
    logic [LEVEL_W:0]      r_acc;
    logic [LEVEL_W-1:0]    r_level;

    logic [LEVEL_W-1:0]    w_sample;
    logic [SumW-1:0]       w_sum;
    logic [LEVEL_W:0]      w_final;
    logic                  w_last;

    assign w_sample = {r_raw, {PadW{1'b0}}};
    assign w_last   = (r_cnt == CntW'(PEAK_W));

    always_comb begin
        w_sum = SumW'(r_acc)
              + (r_mul_a[0] ? SumW'(r_level)  : '0)
              + (r_mul_b[0] ? SumW'(w_sample) : '0);
        // Only the top bit of (1 - w) is left at the last step.
        w_final = r_acc + (r_mul_b[0] ? (LEVEL_W+1)'(w_sample) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_level <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_level <= w_final[LEVEL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mul_a <= i_weight;
            r_mul_b <= {1'b1, {PEAK_W{1'b0}}} - {1'b0, i_weight};
            r_raw   <= i_raw;
            r_acc   <= '0;
        end else if (r_busy && !w_last) begin
            r_mul_a <= r_mul_a >> 1;
            r_mul_b <= r_mul_b >> 1;
            r_acc   <= w_sum[SumW-1:1];
        end
    end

    assign o_level = r_level;
    assign o_done  = r_done;

endmodule

// ----- sv/altm_div.sv -----
// ----------------------------------------------------------------------------
// Tier meter band divider
// Restoring divider, one quotient bit per cycle, for a numerator that is
// below the denominator: quotient = floor((num << QUO_W) / den).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module altm_div #(
    parameter int QUO_W = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [altm_pkg::PEAK_W-1:0]  i_num,
    input  logic [altm_pkg::PEAK_W-1:0]  i_den,
    output logic [QUO_W-1:0]             o_quo,
    output logic                         o_done
);
    import altm_pkg::*;

    localparam int CntW = $clog2(QUO_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CntW-1:0]     r_cnt;
    logic [PEAK_W-1:0]   r_rem;
    logic [PEAK_W-1:0]   r_den;
    logic [QUO_W-1:0]    r_quo;

    logic [PEAK_W:0]     w_dbl;
    logic [PEAK_W:0]     w_diff;
    logic                w_ge;

    assign w_dbl  = {r_rem, 1'b0};
    assign w_ge   = (w_dbl >= {1'b0, r_den});
    assign w_diff = w_dbl - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[PEAK_W-1:0] : w_dbl[PEAK_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

    `ALTM_ASSERT_IMP(a_rem_below_den, o_done, r_rem < r_den,
                     "divider remainder not below denominator")

endmodule

// ----- sv/audio_level_led_tier_meter.sv -----
// ----------------------------------------------------------------------------
// Audio level LED tier meter
// Five-tier bar graph driver with smoothing and a gamma-corrected ramp tier.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready) takes one item per meter
//   tick: left and right peaks with their valid flags. The output channel
//   (o_out_valid / i_out_ready) returns one item per input item: five tier
//   duties, the count of fully lit tiers and the Q0.10 band position.
//   The user must see that thresholds and smoothing weight are written on the
//   i_cfg_* port only while the meter is idle; the block does not enforce it.
//   An accepted item passes through smoothing, band selection, the band
//   divider (only when the level falls inside a non-empty band), gamma
//   lookup and scaling before the result is loaded. One item is processed
//   at a time: the next item is accepted only once the meter has returned
//   to idle. The smoothing multiply is bit-serial, and the restoring band
//   divider produces one quotient bit per cycle while it is running.
//   A finished result sits in the output register while the next item is
//   accepted and processed; if the receiver stalls, the meter holds before
//   loading the next result. Reset restores the default thresholds and
//   weight, clears the smoothed level and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module audio_level_led_tier_meter #(
    parameter int FRACTION_BITS = 10,
    parameter int PWM_MAX       = 255
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [altm_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [altm_pkg::PEAK_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [altm_pkg::PEAK_W-1:0]     i_left_peak,
    input  logic                            i_left_valid,
    input  logic [altm_pkg::PEAK_W-1:0]     i_right_peak,
    input  logic                            i_right_valid,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [altm_pkg::DUTY_W-1:0]     o_tier_one_pwm,
    output logic [altm_pkg::DUTY_W-1:0]     o_tier_two_pwm,
    output logic [altm_pkg::DUTY_W-1:0]     o_tier_three_pwm,
    output logic [altm_pkg::DUTY_W-1:0]     o_tier_four_pwm,
    output logic [altm_pkg::DUTY_W-1:0]     o_tier_five_pwm,
    output logic [altm_pkg::SOLID_W-1:0]    o_solid_tiers,
    output logic [altm_pkg::RAMP_W-1:0]     o_ramp_fraction
);
    import altm_pkg::*;

    localparam int SubW   = FRACTION_BITS - 5;
    localparam int InterW = PEAK_W + SubW;
    localparam int PwmW   = $clog2(PWM_MAX + 1);
    localparam int ScaleW = PEAK_W + PwmW + 1;
    localparam logic [DUTY_W-1:0] FullDuty = DUTY_W'(PWM_MAX);
    localparam logic [SOLID_W-1:0] AllSolid = SOLID_W'(TIERS);

    t_state                    r_state;
    t_state                    n_state;

    logic [PEAK_W-1:0]         r_thr_one;
    logic [PEAK_W-1:0]         r_thr_two;
    logic [PEAK_W-1:0]         r_thr_three;
    logic [PEAK_W-1:0]         r_thr_four;
    logic [PEAK_W-1:0]         r_thr_five;
    logic [PEAK_W-1:0]         r_weight;

    logic [SOLID_W-1:0]        r_solid;
    logic [FRACTION_BITS-1:0]  r_frac;
    logic [PEAK_W-1:0]         r_g;
    logic [DUTY_W-1:0]         r_duty;

    logic                      r_out_valid;
    logic [DUTY_W-1:0]         r_tier_pwm [TIERS];
    logic [SOLID_W-1:0]        r_out_solid;
    logic [RAMP_W-1:0]         r_out_ramp;

    logic                      w_in_ready;
    logic                      w_smooth_start;
    logic                      w_div_start;
    logic                      w_load;

    logic [PEAK_W-1:0]         w_raw;
    logic [LEVEL_W-1:0]        w_level;
    logic                      w_smooth_done;
    logic [PEAK_W-1:0]         w_amp;
    logic [SOLID_W-1:0]        w_solid;
    logic [PEAK_W-1:0]         w_lo;
    logic [PEAK_W-1:0]         w_hi;
    logic                      w_band;
    logic                      w_guard;
    logic [FRACTION_BITS-1:0]  w_quo;
    logic                      w_div_done;

    logic [4:0]                w_idx;
    logic [SubW-1:0]           w_rem;
    logic [PEAK_W-1:0]         w_g_lo;
    logic [PEAK_W-1:0]         w_g_hi;
    logic [InterW-1:0]         w_prod;
    logic [PEAK_W-1:0]         w_interp;
    logic [ScaleW-1:0]         w_scaled;
    logic [RAMP_W-1:0]         w_q10;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_one   <= THR_ONE_RST;
            r_thr_two   <= THR_TWO_RST;
            r_thr_three <= THR_THREE_RST;
            r_thr_four  <= THR_FOUR_RST;
            r_thr_five  <= THR_FIVE_RST;
            r_weight    <= WEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_THR_ONE:   r_thr_one   <= i_cfg_data;
                CFG_THR_TWO:   r_thr_two   <= i_cfg_data;
                CFG_THR_THREE: r_thr_three <= i_cfg_data;
                CFG_THR_FOUR:  r_thr_four  <= i_cfg_data;
                CFG_THR_FIVE:  r_thr_five  <= i_cfg_data;
                CFG_WEIGHT:    r_weight    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------- smoothing
    always_comb begin
        w_raw = i_left_valid ? i_left_peak : '0;
        if (i_right_valid && (i_right_peak > w_raw)) begin
            w_raw = i_right_peak;
        end
    end

    altm_smooth u_smooth (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_smooth_start),
        .i_raw    (w_raw),
        .i_weight (r_weight),
        .o_level  (w_level),
        .o_done   (w_smooth_done)
    );

    // ------------------------------------------------------- band selection
    assign w_amp = w_level[LEVEL_W-1 -: PEAK_W];

    always_comb begin
        w_solid = '0;
        w_lo    = '0;
        w_hi    = '0;
        w_band  = 1'b0;
        priority if (w_amp < r_thr_one) begin
            w_solid = '0;
        end else if (w_amp >= r_thr_five) begin
            w_solid = AllSolid;
        end else if (w_amp < r_thr_two) begin
            w_solid = SOLID_W'(1);
            w_lo    = r_thr_one;
            w_hi    = r_thr_two;
            w_band  = 1'b1;
        end else if (w_amp < r_thr_three) begin
            w_solid = SOLID_W'(2);
            w_lo    = r_thr_two;
            w_hi    = r_thr_three;
            w_band  = 1'b1;
        end else if (w_amp < r_thr_four) begin
            w_solid = SOLID_W'(3);
            w_lo    = r_thr_three;
            w_hi    = r_thr_four;
            w_band  = 1'b1;
        end else begin
            w_solid = SOLID_W'(4);
            w_lo    = r_thr_four;
            w_hi    = r_thr_five;
            w_band  = 1'b1;
        end
        // An empty or inverted band saturates the fraction.
        w_guard = w_band && ((w_hi <= w_lo) || (w_amp < w_lo));
    end

    altm_div #(
        .QUO_W (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_amp - w_lo),
        .i_den   (w_hi - w_lo),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    // ----------------------------------------------------------------- gamma
    assign w_idx    = r_frac[FRACTION_BITS-1 -: 5];
    assign w_rem    = r_frac[SubW-1:0];
    assign w_g_lo   = GAMMA_ROM[{1'b0, w_idx}];
    assign w_g_hi   = GAMMA_ROM[{1'b0, w_idx} + 6'd1];
    assign w_prod   = InterW'(w_g_hi - w_g_lo) * InterW'(w_rem);
    assign w_interp = w_g_lo + PEAK_W'(w_prod >> SubW);
    assign w_scaled = ScaleW'(r_g) * ScaleW'(PWM_MAX) + ScaleW'(32768);
    assign w_q10    = RAMP_W'({r_frac, {RAMP_W{1'b0}}} >> FRACTION_BITS);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_BAND) begin
            r_solid <= w_solid;
            r_frac  <= w_guard ? '1 : '0;
        end else if (r_state == ST_DIVIDE && w_div_done) begin
            r_frac <= w_quo;
        end
        if (r_state == ST_GAMMA) begin
            r_g <= w_interp;
        end
        if (r_state == ST_SCALE) begin
            r_duty <= DUTY_W'(w_scaled >> PEAK_W);
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int k = 0; k < TIERS; k++) begin
                if (r_solid > SOLID_W'(k)) begin
                    r_tier_pwm[k] <= FullDuty;
                end else if (r_solid == SOLID_W'(k)) begin
                    r_tier_pwm[k] <= r_duty;
                end else begin
                    r_tier_pwm[k] <= '0;
                end
            end
            r_out_solid <= r_solid;
            r_out_ramp  <= w_q10;
        end
    end

    // ------------------------------------------------------------------- FSM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SMOOTH;
            ST_SMOOTH: if (w_smooth_done) n_state = ST_BAND;
            ST_BAND:   n_state = (w_band && !w_guard) ? ST_DIVIDE : ST_GAMMA;
            ST_DIVIDE: if (w_div_done) n_state = ST_GAMMA;
            ST_GAMMA:  n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_FINISH;
            ST_FINISH: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready     = 1'b0;
        w_smooth_start = 1'b0;
        w_div_start    = 1'b0;
        w_load         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready     = 1'b1;
                w_smooth_start = i_in_valid;
            end
            ST_BAND:   w_div_start = w_band && !w_guard;
            ST_FINISH: w_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign o_in_ready       = w_in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_tier_one_pwm   = r_tier_pwm[0];
    assign o_tier_two_pwm   = r_tier_pwm[1];
    assign o_tier_three_pwm = r_tier_pwm[2];
    assign o_tier_four_pwm  = r_tier_pwm[3];
    assign o_tier_five_pwm  = r_tier_pwm[4];
    assign o_solid_tiers    = r_out_solid;
    assign o_ramp_fraction  = r_out_ramp;

    // ------------------------------------------------------------ assertions
    `ALTM_ASSERT_NXT(a_accept_starts_smooth, i_in_valid && o_in_ready,
                     r_state == ST_SMOOTH, "accepted item did not start smoothing")
    `ALTM_ASSERT_IMP(a_no_frac_outside_band,
                     (r_state == ST_GAMMA) && ((r_solid == '0) || (r_solid == AllSolid)),
                     r_frac == '0, "fraction nonzero outside a band")
    `ALTM_ASSERT_IMP(a_inner_tier_full, o_out_valid && (o_solid_tiers != '0),
                     o_tier_one_pwm == FullDuty, "solid tier one not at full duty")
    `ALTM_ASSERT_IMP(a_solid_in_range, o_out_valid, o_solid_tiers <= AllSolid,
                     "solid tier count out of range")

endmodule

// ----- test/audio_level_led_tier_meter_tb.sv -----
// ----------------------------------------------------------------------------
// Audio level LED tier meter testbench
// Drives peak items through the valid/ready input channel and predicts each
// result from an in-bench model of the smoothing, band search and gamma
// ramp. Every result is checked field by field against the oldest
// prediction. Directed items cover peak selection, band edges, odd threshold
// sets and extreme weights. Random traffic then runs under several register
// settings and idle mixes on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_level_led_tier_meter_tb;
    import altm_pkg::*;

    localparam int FRAC_BITS      = 10;
    localparam int PWM_FULL       = 255;
    localparam int LATENCY_CYCLES = 23 + FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_SET  = 66;

    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [15:0] GAMMA_CURVE [33] = '{
        16'd0,     16'd32,    16'd147,   16'd359,   16'd676,   16'd1104,
        16'd1648,  16'd2314,  16'd3104,  16'd4022,  16'd5072,  16'd6255,
        16'd7574,  16'd9033,  16'd10632, 16'd12375, 16'd14263, 16'd16298,
        16'd18482, 16'd20816, 16'd23303, 16'd25943, 16'd28739, 16'd31692,
        16'd34802, 16'd38072, 16'd41503, 16'd45097, 16'd48853, 16'd52774,
        16'd56860, 16'd61114, 16'd65535
    };

    typedef struct packed {
        logic [4:0][15:0] thr;
        logic [15:0]      weight;
    } t_meter_cfg;

    typedef struct packed {
        logic [4:0][DUTY_W-1:0] duty;
        logic [SOLID_W-1:0]     lit;
        logic [RAMP_W-1:0]      ramp;
    } t_tier_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [PEAK_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [PEAK_W-1:0]    i_left_peak = '0;
    logic                 i_left_valid = 1'b0;
    logic [PEAK_W-1:0]    i_right_peak = '0;
    logic                 i_right_valid = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [DUTY_W-1:0]    o_tier_one_pwm;
    logic [DUTY_W-1:0]    o_tier_two_pwm;
    logic [DUTY_W-1:0]    o_tier_three_pwm;
    logic [DUTY_W-1:0]    o_tier_four_pwm;
    logic [DUTY_W-1:0]    o_tier_five_pwm;
    logic [SOLID_W-1:0]   o_solid_tiers;
    logic [RAMP_W-1:0]    o_ramp_fraction;

    t_meter_cfg   meter_cfg;
    logic [23:0]  level_q24 = '0;
    t_tier_result expected_tiers [$];
    t_tier_result oldest_tiers;

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          settings_applied = 0;
    int          quiet_cycles = 0;
    int          lit_seen [6] = '{default: 0};

    audio_level_led_tier_meter #(
        .FRACTION_BITS (FRAC_BITS),
        .PWM_MAX       (PWM_FULL)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_left_peak      (i_left_peak),
        .i_left_valid     (i_left_valid),
        .i_right_peak     (i_right_peak),
        .i_right_valid    (i_right_valid),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_tier_one_pwm   (o_tier_one_pwm),
        .o_tier_two_pwm   (o_tier_two_pwm),
        .o_tier_three_pwm (o_tier_three_pwm),
        .o_tier_four_pwm  (o_tier_four_pwm),
        .o_tier_five_pwm  (o_tier_five_pwm),
        .o_solid_tiers    (o_solid_tiers),
        .o_ramp_fraction  (o_ramp_fraction)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_meter_cfg default_settings();
        t_meter_cfg c;
        c.thr[0] = 16'd1311;
        c.thr[1] = 16'd9830;
        c.thr[2] = 16'd22938;
        c.thr[3] = 16'd39322;
        c.thr[4] = 16'd55706;
        c.weight = 16'd52429;
        return c;
    endfunction

    // Advances the smoothed level by one tick and maps it onto the tiers.
    function automatic t_tier_result predict_tiers(input logic [15:0] lp, input logic lv,
                                                   input logic [15:0] rp, input logic rv);
        logic [15:0]  raw;
        logic [63:0]  acc;
        logic [15:0]  amp;
        logic [31:0]  ramp_q;
        logic [31:0]  fmax;
        logic [31:0]  idx;
        logic [31:0]  rem;
        logic [31:0]  interp;
        logic [31:0]  ramp_duty;
        logic [2:0]   lit;
        logic         found;
        t_tier_result r;
        raw = lv ? lp : 16'd0;
        if (rv && rp > raw) raw = rp;
        acc = 64'(meter_cfg.weight) * 64'(level_q24)
            + (64'd65536 - 64'(meter_cfg.weight)) * (64'(raw) << 8);
        level_q24 = acc[39:16];
        amp = level_q24[23:8];
        fmax = (32'd1 << FRAC_BITS) - 1;
        ramp_q = '0;
        found = 1'b0;
        if (amp < meter_cfg.thr[0]) begin
            lit = 3'd0;
        end else if (amp >= meter_cfg.thr[4]) begin
            lit = 3'd5;
        end else begin
            lit = 3'd5;
            for (int b = 0; b < 4; b++) begin
                if (!found && amp < meter_cfg.thr[b+1]) begin
                    found = 1'b1;
                    lit = 3'(b + 1);
                    if (meter_cfg.thr[b+1] <= meter_cfg.thr[b] || amp < meter_cfg.thr[b]) begin
                        ramp_q = fmax;
                    end else begin
                        ramp_q = ((32'(amp) - 32'(meter_cfg.thr[b])) << FRAC_BITS)
                               / (32'(meter_cfg.thr[b+1]) - 32'(meter_cfg.thr[b]));
                        if (ramp_q > fmax) ramp_q = fmax;
                    end
                end
            end
        end
        // The top five fraction bits pick a curve segment, the rest interpolate.
        idx = ramp_q >> (FRAC_BITS - 5);
        rem = ramp_q & ((32'd1 << (FRAC_BITS - 5)) - 1);
        interp = 32'(GAMMA_CURVE[idx])
               + (((32'(GAMMA_CURVE[idx+1]) - 32'(GAMMA_CURVE[idx])) * rem) >> (FRAC_BITS - 5));
        ramp_duty = (interp * PWM_FULL + 32'd32768) >> 16;
        for (int t = 0; t < 5; t++) begin
            if (lit >= t + 1) r.duty[t] = 8'(PWM_FULL);
            else if (lit == t) r.duty[t] = ramp_duty[7:0];
            else r.duty[t] = '0;
        end
        r.lit = lit;
        r.ramp = ramp_q[RAMP_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tiers.size() == 0) begin
                $error("result arrived with no item outstanding");
                mismatches++;
            end else begin
                oldest_tiers = expected_tiers.pop_front();
                check_field("tier_one_pwm", oldest_tiers.duty[0], o_tier_one_pwm);
                check_field("tier_two_pwm", oldest_tiers.duty[1], o_tier_two_pwm);
                check_field("tier_three_pwm", oldest_tiers.duty[2], o_tier_three_pwm);
                check_field("tier_four_pwm", oldest_tiers.duty[3], o_tier_four_pwm);
                check_field("tier_five_pwm", oldest_tiers.duty[4], o_tier_five_pwm);
                check_field("solid_tiers", oldest_tiers.lit, o_solid_tiers);
                check_field("ramp_fraction", oldest_tiers.ramp, o_ramp_fraction);
                if (oldest_tiers.lit <= 5) lit_seen[oldest_tiers.lit]++;
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic send_item(input logic [15:0] lp, input logic lv,
                             input logic [15:0] rp, input logic rv);
        int gap;
        @(negedge i_clk);
        gap = 0;
        // Now and then a long gap, so idle time lands deep inside processing.
        if (sender_idle_pct != 0 && $urandom_range(0, 15) == 0) gap = $urandom_range(1, 40);
        while (gap > 0 || $urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            if (gap > 0) gap--;
        end
        i_left_peak   <= lp;
        i_left_valid  <= lv;
        i_right_peak  <= rp;
        i_right_valid <= rv;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        expected_tiers.push_back(predict_tiers(lp, lv, rp, rv));
        items_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_tiers.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_THR_ONE:   meter_cfg.thr[0] = data;
            CFG_THR_TWO:   meter_cfg.thr[1] = data;
            CFG_THR_THREE: meter_cfg.thr[2] = data;
            CFG_THR_FOUR:  meter_cfg.thr[3] = data;
            CFG_THR_FIVE:  meter_cfg.thr[4] = data;
            CFG_WEIGHT:    meter_cfg.weight = data;
            default: ;
        endcase
    endtask

    // Writes all six registers plus the two unused indexes, which must be ignored.
    task automatic apply_settings(input t_meter_cfg c);
        wait_results_drained();
        write_reg(CFG_THR_ONE, c.thr[0]);
        write_reg(CFG_THR_TWO, c.thr[1]);
        write_reg(CFG_THR_THREE, c.thr[2]);
        write_reg(CFG_THR_FOUR, c.thr[3]);
        write_reg(CFG_THR_FIVE, c.thr[4]);
        write_reg(CFG_WEIGHT, c.weight);
        write_reg(CFG_SPARE_LO, 16'($urandom_range(0, 65535)));
        write_reg(CFG_SPARE_HI, 16'($urandom_range(0, 65535)));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    function automatic t_meter_cfg random_settings();
        t_meter_cfg  c;
        logic [15:0] tmp;
        int          kind;
        int          k;
        for (int i = 0; i < 5; i++) c.thr[i] = 16'($urandom_range(0, 65535));
        kind = $urandom_range(0, 5);
        if (kind != 4) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4 - i; j++) begin
                    if (c.thr[j] > c.thr[j+1]) begin
                        tmp = c.thr[j];
                        c.thr[j] = c.thr[j+1];
                        c.thr[j+1] = tmp;
                    end
                end
            end
        end
        if (kind == 3) begin
            c.thr[0] = 16'd0;
            c.thr[4] = 16'hFFFF;
        end else if (kind == 5) begin
            k = $urandom_range(0, 3);
            c.thr[k+1] = c.thr[k];
        end
        case ($urandom_range(0, 3))
            0:       c.weight = 16'd0;
            1:       c.weight = 16'($urandom_range(0, 65535));
            default: c.weight = 16'($urandom_range(0, 32767));
        endcase
        return c;
    endfunction

    function automatic logic [15:0] random_peak();
        int p;
        case ($urandom_range(0, 9))
            0:       p = 0;
            1:       p = 65535;
            2, 3: begin
                p = int'(meter_cfg.thr[$urandom_range(0, 4)]) + int'($urandom_range(0, 4)) - 2;
                if (p < 0) p = 0;
                if (p > 65535) p = 65535;
            end
            default: p = $urandom_range(0, 65535);
        endcase
        return 16'(p);
    endfunction

    // Mostly runs of items that hold one target level so the average settles
    // into a band, with fully random items mixed in.
    task automatic run_traffic(input int count);
        logic [15:0] target;
        logic [15:0] lp;
        logic [15:0] rp;
        target = random_peak();
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_results_drained();
            if ($urandom_range(0, 5) == 0) target = random_peak();
            if ($urandom_range(0, 3) == 0) begin
                send_item(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                          16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            end else begin
                lp = target;
                rp = 16'($urandom_range(0, target));
                if ($urandom_range(0, 1) == 1) begin
                    send_item(lp, 1'b1, rp, 1'($urandom_range(0, 1)));
                end else begin
                    send_item(rp, 1'($urandom_range(0, 1)), lp, 1'b1);
                end
            end
        end
    endtask

    task automatic test_peak_select();
        send_item(16'hFFFF, 1'b1, 16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0, 16'h1234, 1'b1);
        send_item(16'hC000, 1'b1, 16'h4000, 1'b1);
        send_item(16'h4000, 1'b1, 16'hC000, 1'b1);
        send_item(16'h8001, 1'b1, 16'h8001, 1'b1);
        send_item(16'hFFFF, 1'b0, 16'hFFFF, 1'b0);
        send_item(16'h0000, 1'b1, 16'h0000, 1'b1);
    endtask

    // With zero weight the level follows the peak exactly, so each band
    // boundary can be hit on the nose.
    task automatic test_band_edges();
        int         band_amps [11] = '{0, 1310, 1311, 5000, 9829, 9830, 30000,
                                       39321, 55705, 55706, 65535};
        t_meter_cfg c;
        c = default_settings();
        c.weight = 16'd0;
        apply_settings(c);
        foreach (band_amps[i]) begin
            send_item(16'(band_amps[i]), 1'b1, 16'($urandom_range(0, band_amps[i])), 1'b1);
        end
    endtask

    task automatic test_odd_thresholds();
        t_meter_cfg c;
        // Out of order with a repeated pair: the scan picks the first higher one.
        c.thr[0] = 16'd20000;
        c.thr[1] = 16'd10000;
        c.thr[2] = 16'd30000;
        c.thr[3] = 16'd30000;
        c.thr[4] = 16'd60000;
        c.weight = 16'd0;
        apply_settings(c);
        send_item(16'd25000, 1'b1, 16'd0, 1'b0);
        send_item(16'd30000, 1'b0, 16'd30000, 1'b1);
        send_item(16'd59999, 1'b1, 16'd100, 1'b1);
        c.thr = {5{16'hFFFF}};
        apply_settings(c);
        send_item(16'hFFFE, 1'b1, 16'd0, 1'b1);
        send_item(16'hFFFF, 1'b1, 16'd0, 1'b1);
        c.thr = {5{16'h0000}};
        apply_settings(c);
        send_item(16'h0000, 1'b0, 16'h0000, 1'b0);
    endtask

    task automatic test_weight_extremes();
        t_meter_cfg c;
        c = default_settings();
        c.weight = 16'hFFFF;
        apply_settings(c);
        send_item(16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
        send_item(16'hFFFF, 1'b1, 16'h0000, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned idle_mix [4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{11, 11}};
        for (int m = 0; m < 4; m++) begin
            sender_idle_pct = idle_mix[m][0];
            receiver_stall_pct = idle_mix[m][1];
            for (int s = 0; s < 2; s++) begin
                apply_settings(random_settings());
                run_traffic(ITEMS_PER_SET);
            end
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
    endtask

    initial begin
        meter_cfg = default_settings();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_peak_select();
        test_band_edges();
        test_odd_thresholds();
        test_weight_extremes();
        test_random_traffic();
        wait_results_drained();
        repeat (LATENCY_CYCLES + 8) @(posedge i_clk);
        if (expected_tiers.size() != 0) begin
            $error("%0d results never arrived", expected_tiers.size());
            mismatches++;
        end
        $display("Summary: %0d items sent, %0d results compared, %0d register settings used",
                 items_sent, results_checked, settings_applied);
        $display("Results per count of lit tiers (0 to 5): %0d %0d %0d %0d %0d %0d",
                 lit_seen[0], lit_seen[1], lit_seen[2], lit_seen[3], lit_seen[4], lit_seen[5]);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- audio_level_led_tier_meter.f -----
+incdir+sv
sv/altm_pkg.sv
sv/altm_smooth.sv
sv/altm_div.sv
sv/audio_level_led_tier_meter.sv
test/audio_level_led_tier_meter_tb.sv
